[hw/rtl/base64_stream_decoder_core_defines.svh]
// ---------------------------------------------------------------------------
// Base64 stream decoder assertion macros
// Shared assertion wrappers; compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef BASE64_STREAM_DECODER_CORE_DEFINES_SVH
`define BASE64_STREAM_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define B64D_ASSERT_NOW(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error(msg);
// Next-cycle implication, checked out of reset.
`define B64D_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error(msg);
`else
`define B64D_ASSERT_NOW(label, clk, rst_n, a, c, msg)
`define B64D_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif

`endif

[hw/rtl/b64d_pkg.sv]
// ---------------------------------------------------------------------------
// b64d_pkg
// Types and character constants for the base64 stream decoder.
// ---------------------------------------------------------------------------
package b64d_pkg;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_DIG_LO = 8'h30;
  localparam logic [7:0] CH_DIG_HI = 8'h39;
  localparam logic [7:0] CH_LOW_LO = 8'h61;
  localparam logic [7:0] CH_LOW_HI = 8'h7A;
  localparam logic [7:0] CH_UP_LO  = 8'h41;
  localparam logic [7:0] CH_UP_HI  = 8'h5A;

  localparam logic [5:0] SX_PLUS   = 6'd62;
  localparam logic [5:0] SX_SLASH  = 6'd63;
  localparam logic [5:0] SX_DIG    = 6'd52;
  localparam logic [5:0] SX_LOW    = 6'd26;

  localparam logic [1:0] LAST_SLOT = 2'd3;

  typedef logic [5:0] sextet_t;

  // Result of mapping one character.
  typedef struct packed {
    logic    ok;
    sextet_t sx;
  } map_t;

  // One decoded result item.
  typedef struct packed {
    logic       group_done;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic       char_rejected;
  } result_t;

  // Group state seen by the top level.
  typedef struct packed {
    logic [1:0]  count;
    logic [17:0] held;
  } grp_status_t;

endpackage

[hw/rtl/base64_stream_decoder_core.sv]
// ---------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: one character in, one result item out.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one ASCII character per item plus
//   an end-of-chunk flag that drops any partial group after that character.
//   Output channel (out_valid / out_stall): exactly one result item per
//   input item, in order. group_done marks the fourth valid sextet of a
//   group and carries three decoded bytes; otherwise the bytes read 0.
//   char_rejected flags a byte outside the base64 alphabet ('=' maps to 0).
//   Pipeline: an accepted item passes the input register, then the result
//   register, before out_valid rises. Throughput: one item per cycle while
//   out_stall is low; the only loop is the sextet count/hold register.
//   Stall: while out_stall holds a full result register, an empty input
//   register still takes one item, then holds, and in_stall rises in the
//   cycle after; nothing is dropped.
//   Reset (synchronous, rst_n low): pipeline empties, group state clears.
// ---------------------------------------------------------------------------
`include "base64_stream_decoder_core_defines.svh"

module base64_stream_decoder_core
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_chunk,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_group_done,
  output logic [7:0] out_byte_first,
  output logic [7:0] out_byte_second,
  output logic [7:0] out_byte_third,
  output logic       out_char_rejected
);

  // Stage 1: input register
  logic        s1_valid_r;
  logic [7:0]  s1_char_r;
  logic        s1_eoc_r;

  // Stage 2: result register
  logic        out_valid_r;
  result_t     out_res_r;

  logic        out_adv;   // result register may load
  logic        s1_adv;    // input register may load
  logic        s2_fire;   // stage 1 item moves into result register
  map_t        map;
  result_t     res;
  grp_status_t grp_status;

  // check terms
  logic        out_done;        // valid result that closes a group
  logic        out_idle;        // valid result without a group
  logic        out_bytes_zero;  // all three bytes are 0
  logic        rej_fire;        // rejected char leaves stage 1, no chunk end
  logic        eoc_fire;        // chunk end leaves stage 1

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = !s1_valid_r || out_adv;
  assign s2_fire  = s1_valid_r && out_adv;
  assign in_stall = !s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_valid;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_char_r <= in_char_in;
      s1_eoc_r  <= in_end_of_chunk;
    end
  end

  b64d_char_map u_char_map (
    .char_i (s1_char_r),
    .map_o  (map)
  );

  // group state advances only when the item leaves stage 1
  b64d_group_unit u_group (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire_i   (s2_fire),
    .map_i    (map),
    .eoc_i    (s1_eoc_r),
    .res_o    (res),
    .status_o (grp_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_group_done    = out_res_r.group_done;
  assign out_byte_first    = out_res_r.byte_first;
  assign out_byte_second   = out_res_r.byte_second;
  assign out_byte_third    = out_res_r.byte_third;
  assign out_char_rejected = out_res_r.char_rejected;

  assign out_done       = out_valid_r && out_res_r.group_done;
  assign out_idle       = out_valid_r && !out_res_r.group_done;
  assign out_bytes_zero = (out_res_r.byte_first == 8'd0) &&
                          (out_res_r.byte_second == 8'd0) &&
                          (out_res_r.byte_third == 8'd0);
  assign rej_fire       = s2_fire && !map.ok && !s1_eoc_r;
  assign eoc_fire       = s2_fire && s1_eoc_r;

  // ---- assertions ----
  `B64D_ASSERT_NOW(a_done_not_rej, clk, rst_n, out_done, !out_char_rejected, "done on reject")
  `B64D_ASSERT_NOW(a_idle_bytes_zero, clk, rst_n, out_idle, out_bytes_zero, "bytes, no group")
  `B64D_ASSERT_NXT(a_rej_keeps_state, clk, rst_n, rej_fire, $stable(grp_status), "reject moved")
  `B64D_ASSERT_NXT(a_eoc_clears, clk, rst_n, eoc_fire, grp_status == '0, "partial group kept")
  `B64D_ASSERT_NXT(a_hold_no_fire, clk, rst_n, !s2_fire, $stable(grp_status), "idle state moved")

endmodule

[hw/rtl/b64d_char_map.sv]
// ---------------------------------------------------------------------------
// b64d_char_map
// Maps one ASCII character to its base64 sextet, flags non-alphabet bytes.
// ---------------------------------------------------------------------------
module b64d_char_map
  import b64d_pkg::*;
(
  input  logic [7:0] char_i,
  output map_t       map_o
);

  logic [7:0] dig_off;
  logic [7:0] low_off;
  logic [7:0] up_off;

  assign dig_off = char_i - CH_DIG_LO;
  assign low_off = char_i - CH_LOW_LO;
  assign up_off  = char_i - CH_UP_LO;

  always_comb begin
    map_o = '0;
    if (char_i == CH_PLUS) begin
      map_o = '{ok: 1'b1, sx: SX_PLUS};
    end else if (char_i == CH_SLASH) begin
      map_o = '{ok: 1'b1, sx: SX_SLASH};
    end else if (char_i == CH_EQUAL) begin
      map_o = '{ok: 1'b1, sx: 6'd0};
    end else if (char_i >= CH_DIG_LO && char_i <= CH_DIG_HI) begin
      map_o = '{ok: 1'b1, sx: dig_off[5:0] + SX_DIG};
    end else if (char_i >= CH_LOW_LO && char_i <= CH_LOW_HI) begin
      map_o = '{ok: 1'b1, sx: low_off[5:0] + SX_LOW};
    end else if (char_i >= CH_UP_LO && char_i <= CH_UP_HI) begin
      map_o = '{ok: 1'b1, sx: up_off[5:0]};
    end
  end

endmodule

[hw/rtl/b64d_group_unit.sv]
// ---------------------------------------------------------------------------
// b64d_group_unit
// Holds up to three sextets and assembles three bytes on the fourth.
// ---------------------------------------------------------------------------
module b64d_group_unit
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire_i,
  input  map_t        map_i,
  input  logic        eoc_i,
  output result_t     res_o,
  output grp_status_t status_o
);

  logic [1:0]  count_r, count_nxt;
  logic [17:0] held_r, held_nxt;
  sextet_t     s0, s1, s2;

  assign s0 = held_r[17:12];
  assign s1 = held_r[11:6];
  assign s2 = held_r[5:0];

  always_comb begin
    res_o     = '0;
    count_nxt = count_r;
    held_nxt  = held_r;
    if (map_i.ok) begin
      if (count_r == LAST_SLOT) begin
        res_o.group_done  = 1'b1;
        res_o.byte_first  = {s0, s1[5:4]};
        res_o.byte_second = {s1[3:0], s2[5:2]};
        res_o.byte_third  = {s2[1:0], map_i.sx};
        count_nxt         = '0;
        held_nxt          = '0;
      end else begin
        held_nxt  = {held_r[11:0], map_i.sx};
        count_nxt = count_r + 2'd1;
      end
    end else begin
      res_o.char_rejected = 1'b1;
    end
    if (eoc_i) begin
      count_nxt = '0;
      held_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      held_r  <= '0;
    end else if (fire_i) begin
      count_r <= count_nxt;
      held_r  <= held_nxt;
    end
  end

  assign status_o = '{count: count_r, held: held_r};

endmodule
